// File: rtl/lfsm_pkg.sv
// Shared types, codes and a helper function for the LED fade controller.
// No dependencies; the divider, the top level and the testbench refer to it by scoped names.
package lfsm_pkg;

  // Widths of the configuration registers and the fade arithmetic.
  localparam int unsigned RegW     = 16;
  localparam int unsigned FracBits = 10;
  localparam int unsigned DivW     = RegW + FracBits;
  localparam int unsigned DivCntW  = $clog2(DivW);
  localparam int unsigned ProdW    = DivW + RegW;

  // Configuration register indexes.
  localparam logic [2:0] REG_PERIOD   = 3'd0;
  localparam logic [2:0] REG_FADE_IN  = 3'd1;
  localparam logic [2:0] REG_FADE_OFF = 3'd2;
  localparam logic [2:0] REG_PWM_MIN  = 3'd3;
  localparam logic [2:0] REG_PWM_MAX  = 3'd4;

  // LED modes; MODE_KEEP only appears as a transition result.
  localparam logic [2:0] MODE_OFF      = 3'd0;
  localparam logic [2:0] MODE_FADE_IN  = 3'd1;
  localparam logic [2:0] MODE_ON       = 3'd2;
  localparam logic [2:0] MODE_FADE_OFF = 3'd3;
  localparam logic [2:0] MODE_KEEP     = 3'd4;

  // Per-LED event codes.
  localparam logic [2:0] EV_NONE      = 3'd0;
  localparam logic [2:0] EV_ON        = 3'd1;
  localparam logic [2:0] EV_OFF       = 3'd2;
  localparam logic [2:0] EV_FORCE_ON  = 3'd3;
  localparam logic [2:0] EV_FORCE_OFF = 3'd4;

  // Kind of duty update queued for one LED.
  typedef enum logic [1:0] {
    EM_ZERO,
    EM_MAX,
    EM_RAMP
  } em_kind_e;

  // One word of the per-LED state memory.
  typedef struct packed {
    logic [1:0]      mode;
    logic [RegW-1:0] fade_step;
  } led_state_t;

  // Transition table: next mode for a given mode and event.
  function automatic logic [2:0] next_mode(input logic [1:0] mode, input logic [2:0] ev);
    logic [2:0] nxt;
    nxt = MODE_KEEP;
    case (mode)
      MODE_OFF[1:0]: begin
        if (ev == EV_ON) nxt = MODE_FADE_IN;
        else if (ev == EV_FORCE_ON) nxt = MODE_ON;
      end
      MODE_FADE_IN[1:0], MODE_FADE_OFF[1:0]: begin
        if (ev == EV_OFF || ev == EV_FORCE_OFF) nxt = MODE_OFF;
        else if (ev == EV_FORCE_ON) nxt = MODE_ON;
      end
      MODE_ON[1:0]: begin
        if (ev == EV_OFF) nxt = MODE_FADE_OFF;
        else if (ev == EV_FORCE_OFF) nxt = MODE_OFF;
      end
      default: nxt = MODE_KEEP;
    endcase
    return nxt;
  endfunction

endpackage

// File: rtl/lfsm_if.sv
// Valid/ready stream interfaces for the tick input and the duty results.
// Depends on nothing; used by the top level of the LED fade controller.
interface lfsm_in_if;
  logic        valid;
  logic        ready;
  logic [11:0] events;

  modport source (output valid, output events, input ready);
  modport sink (input valid, input events, output ready);
endinterface

interface lfsm_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  led;
  logic [15:0] duty;
  logic        last;

  modport source (output valid, output led, output duty, output last, input ready);
  modport sink (input valid, input led, input duty, input last, output ready);
endinterface

// File: rtl/lfsm_div.sv
// Restoring divider, one quotient bit per cycle, for the fade step counts and slopes.
// Depends on lfsm_pkg for the operand widths.
module lfsm_div (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [lfsm_pkg::DivW-1:0]    dividend_i,
  input  logic [lfsm_pkg::RegW-1:0]    divisor_i,
  output logic                         busy_o,
  output logic [lfsm_pkg::DivW-1:0]    quotient_o
);

  logic                         busy_q;
  logic [lfsm_pkg::DivCntW-1:0] cnt_q;
  logic [lfsm_pkg::DivW-1:0]    dvd_q;
  logic [lfsm_pkg::RegW-1:0]    rem_q;
  logic [lfsm_pkg::RegW-1:0]    dsr_q;
  logic [lfsm_pkg::RegW:0]      rem_sh;
  logic                         ge;

  // Shift in the next dividend bit and try a subtraction.
  assign rem_sh = {rem_q, dvd_q[lfsm_pkg::DivW-1]};
  assign ge     = rem_sh >= {1'b0, dsr_q};

  // Control: busy from a start until all DivW quotient bits are shifted in.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == lfsm_pkg::DivCntW'(lfsm_pkg::DivW - 1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  // Datapath: quotient bits shift into the dividend register.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= ge ? lfsm_pkg::RegW'(rem_sh - {1'b0, dsr_q}) : rem_sh[lfsm_pkg::RegW-1:0];
      dvd_q <= {dvd_q[lfsm_pkg::DivW-2:0], ge};
    end
  end

  assign busy_o     = busy_q;
  assign quotient_o = dvd_q;

endmodule

// File: rtl/led_fade_state_machine.sv
// LED fade controller top level: tick divider, per-LED state memory, fade arithmetic.
// A tick that does not service is taken straight from idle. A service tick holds off the next
// tick through two divider runs (step counts, then slopes), then a read, an evaluation and
// up to two emits per LED, and a closing state, plus output stalls.
// No result beat is offered before both divider runs and the first evaluation are done.
// Async active-low reset: config and control registers zero, LEDs OFF with fade step 0.
module led_fade_state_machine #(
  parameter int unsigned LED_COUNT = 4
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [2:0]        cfg_idx_i,
  input  logic [15:0]       cfg_wdata_i,
  lfsm_in_if.sink           in_if,
  lfsm_out_if.source        out_if
);

  localparam int unsigned IdxW = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
  localparam int unsigned RegW = lfsm_pkg::RegW;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_DIVS = 3'd1;
  localparam logic [2:0] ST_DIVQ = 3'd2;
  localparam logic [2:0] ST_READ = 3'd3;
  localparam logic [2:0] ST_EVAL = 3'd4;
  localparam logic [2:0] ST_EMIT = 3'd5;
  localparam logic [2:0] ST_FIN  = 3'd6;

  // Configuration registers.
  logic [RegW-1:0] period_q, fade_in_q, fade_off_q, pwm_min_q, pwm_max_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q   <= '0;
      fade_in_q  <= '0;
      fade_off_q <= '0;
      pwm_min_q  <= '0;
      pwm_max_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        lfsm_pkg::REG_PERIOD:   period_q   <= cfg_wdata_i;
        lfsm_pkg::REG_FADE_IN:  fade_in_q  <= cfg_wdata_i;
        lfsm_pkg::REG_FADE_OFF: fade_off_q <= cfg_wdata_i;
        lfsm_pkg::REG_PWM_MIN:  pwm_min_q  <= cfg_wdata_i;
        lfsm_pkg::REG_PWM_MAX:  pwm_max_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // Control and working registers.
  logic [2:0]                  state_q;
  logic [RegW-1:0]             tick_div_q;
  logic [11:0]                 events_q;
  logic [IdxW-1:0]             led_idx_q;
  logic [RegW-1:0]             steps_in_q, steps_off_q;
  logic [lfsm_pkg::DivW-1:0]   q_in_q, q_off_q;
  logic [lfsm_pkg::ProdW-1:0]  product_q;
  logic [1:0]                  em_cnt_q;
  logic                        em_pos_q;
  lfsm_pkg::em_kind_e          em_kind_q [2];
  logic                        ramp_rise_q;
  logic                        pend_valid_q;
  logic [1:0]                  pend_led_q;
  logic [RegW-1:0]             pend_duty_q;
  logic                        out_valid_q;
  logic [1:0]                  out_led_q;
  logic [RegW-1:0]             out_duty_q;
  logic                        out_last_q;

  // Per-LED state memory with reset valid bits.
  lfsm_pkg::led_state_t        mem_q [LED_COUNT];
  logic [LED_COUNT-1:0]        mem_vld_q;
  lfsm_pkg::led_state_t        rd_data_q;
  logic                        rd_vld_q;
  lfsm_pkg::led_state_t        wr_data;
  logic                        wr_en;

  // Tick handshake and divider decision.
  logic              in_beat;
  logic [RegW:0]     tick_cnt;
  logic              service;

  assign in_if.ready = (state_q == ST_IDLE);
  assign in_beat     = in_if.valid && in_if.ready;
  assign tick_cnt    = {1'b0, tick_div_q} + 1'b1;
  assign service     = (period_q != '0) && !(tick_cnt < {1'b0, period_q});

  // Shared dividers: first the step counts, then the fixed-point slopes.
  logic                       div_start, busy_in, busy_off;
  logic [lfsm_pkg::DivW-1:0]  quo_in, quo_off;
  logic [lfsm_pkg::DivW-1:0]  dvd_in, dvd_off;
  logic [RegW-1:0]            dsr_in, dsr_off;
  logic [RegW-1:0]            pwm_diff;
  logic                       divs_done;

  assign pwm_diff  = (pwm_max_q > pwm_min_q) ? pwm_max_q - pwm_min_q : '0;
  assign divs_done = !busy_in && !busy_off;
  assign div_start = (in_beat && service) || (state_q == ST_DIVS && divs_done);
  assign dvd_in    = (state_q == ST_IDLE) ? lfsm_pkg::DivW'(fade_in_q)
                                          : {pwm_diff, {lfsm_pkg::FracBits{1'b0}}};
  assign dvd_off   = (state_q == ST_IDLE) ? lfsm_pkg::DivW'(fade_off_q)
                                          : {pwm_diff, {lfsm_pkg::FracBits{1'b0}}};
  assign dsr_in    = (state_q == ST_IDLE) ? period_q : quo_in[RegW-1:0];
  assign dsr_off   = (state_q == ST_IDLE) ? period_q : quo_off[RegW-1:0];

  lfsm_div u_div_in (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd_in),
    .divisor_i  (dsr_in),
    .busy_o     (busy_in),
    .quotient_o (quo_in)
  );

  lfsm_div u_div_off (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (dvd_off),
    .divisor_i  (dsr_off),
    .busy_o     (busy_off),
    .quotient_o (quo_off)
  );

  // Evaluate one LED: event transition, then the fade action.
  lfsm_pkg::led_state_t        cur;
  logic [2:0]                  ev;
  logic [2:0]                  to_mode;
  logic [1:0]                  m1;
  logic [RegW-1:0]             fs1, fs2;
  logic                        in_fade, rising, fade_end;
  logic [RegW-1:0]             steps_sel;
  logic [lfsm_pkg::DivW-1:0]   q_sel;
  logic [1:0]                  em_cnt_d;
  lfsm_pkg::em_kind_e          em_k0_d, em_k1_d;

  always_comb begin
    cur = rd_vld_q ? rd_data_q : '0;
    ev  = 3'(events_q >> (4'(led_idx_q) * 4'd3));
    if (ev > lfsm_pkg::EV_FORCE_OFF) ev = lfsm_pkg::EV_NONE;
    to_mode  = lfsm_pkg::next_mode(cur.mode, ev);
    em_cnt_d = '0;
    em_k0_d  = lfsm_pkg::EM_ZERO;
    em_k1_d  = lfsm_pkg::EM_ZERO;
    m1       = cur.mode;
    fs1      = cur.fade_step;
    // Transition from the event.
    if (to_mode != lfsm_pkg::MODE_KEEP) begin
      if (cur.mode == lfsm_pkg::MODE_FADE_OFF[1:0]) begin
        em_k0_d  = lfsm_pkg::EM_ZERO;
        em_cnt_d = 2'd1;
      end
      if (cur.mode == lfsm_pkg::MODE_FADE_IN[1:0]) fs1 = '0;
      m1 = to_mode[1:0];
      if (to_mode == lfsm_pkg::MODE_OFF || to_mode == lfsm_pkg::MODE_ON) begin
        if (em_cnt_d == 2'd0) begin
          em_k0_d = (to_mode == lfsm_pkg::MODE_ON) ? lfsm_pkg::EM_MAX : lfsm_pkg::EM_ZERO;
        end else begin
          em_k1_d = (to_mode == lfsm_pkg::MODE_ON) ? lfsm_pkg::EM_MAX : lfsm_pkg::EM_ZERO;
        end
        em_cnt_d = em_cnt_d + 2'd1;
      end else begin
        fs1 = '0;
      end
    end
    // Fade action; entering a fade emits nothing, so the list is empty here.
    in_fade   = (m1 == lfsm_pkg::MODE_FADE_IN[1:0]) || (m1 == lfsm_pkg::MODE_FADE_OFF[1:0]);
    rising    = (m1 == lfsm_pkg::MODE_FADE_IN[1:0]);
    steps_sel = rising ? steps_in_q : steps_off_q;
    q_sel     = rising ? q_in_q : q_off_q;
    fs2       = (fs1 == '1) ? fs1 : fs1 + 1'b1;
    fade_end  = in_fade && (fs2 >= steps_sel);
    wr_data.mode      = m1;
    wr_data.fade_step = fs1;
    if (in_fade) begin
      wr_data.fade_step = fs2;
      if (fade_end && rising) begin
        wr_data.mode      = lfsm_pkg::MODE_ON[1:0];
        wr_data.fade_step = '0;
        em_k0_d           = lfsm_pkg::EM_MAX;
        em_cnt_d          = 2'd1;
      end else if (fade_end) begin
        wr_data.mode = lfsm_pkg::MODE_OFF[1:0];
        em_k0_d      = lfsm_pkg::EM_ZERO;
        em_k1_d      = lfsm_pkg::EM_ZERO;
        em_cnt_d     = 2'd2;
      end else begin
        em_k0_d  = lfsm_pkg::EM_RAMP;
        em_cnt_d = 2'd1;
      end
    end
  end

  assign wr_en = (state_q == ST_EVAL);

  // State memory: registered read at the current LED, write-back from evaluation.
  always_ff @(posedge clk_i) begin
    rd_data_q <= mem_q[led_idx_q];
    if (wr_en) mem_q[led_idx_q] <= wr_data;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mem_vld_q <= '0;
      rd_vld_q  <= 1'b0;
    end else begin
      rd_vld_q <= mem_vld_q[led_idx_q];
      if (wr_en) mem_vld_q[led_idx_q] <= 1'b1;
    end
  end

  // Duty of the queued update at the current position.
  lfsm_pkg::em_kind_e  cur_kind;
  logic [31:0]         ramp;
  logic [31:0]         duty_raw;
  logic [RegW-1:0]     duty_sel;

  always_comb begin
    cur_kind = em_kind_q[em_pos_q];
    ramp     = product_q[lfsm_pkg::ProdW-1:lfsm_pkg::FracBits];
    if (ramp_rise_q) duty_raw = ramp;
    else if (ramp > 32'(pwm_max_q)) duty_raw = 32'(pwm_max_q);
    else duty_raw = 32'(pwm_max_q) - ramp;
    case (cur_kind)
      lfsm_pkg::EM_ZERO: duty_sel = '0;
      lfsm_pkg::EM_MAX:  duty_sel = pwm_max_q;
      lfsm_pkg::EM_RAMP: begin
        if (duty_raw > 32'(pwm_max_q)) duty_sel = pwm_max_q;
        else if (duty_raw < 32'(pwm_min_q)) duty_sel = pwm_min_q;
        else duty_sel = duty_raw[RegW-1:0];
      end
      default: duty_sel = '0;
    endcase
  end

  // Output slot is free when empty or being taken this cycle.
  logic out_free, last_led, out_load;
  assign out_free = !out_valid_q || out_if.ready;
  assign last_led = (led_idx_q == IdxW'(LED_COUNT - 1));
  assign out_load = pend_valid_q && out_free && (state_q == ST_EMIT || state_q == ST_FIN);

  // Output valid: set when the pending result moves out, cleared when taken.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_if.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Sequencer and pending result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      tick_div_q   <= '0;
      led_idx_q    <= '0;
      em_cnt_q     <= '0;
      em_pos_q     <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_beat) begin
            if (period_q == '0) begin
              tick_div_q <= '0;
            end else if (!service) begin
              tick_div_q <= tick_cnt[RegW-1:0];
            end else begin
              tick_div_q <= '0;
              state_q    <= ST_DIVS;
            end
          end
        end
        ST_DIVS: begin
          if (divs_done) state_q <= ST_DIVQ;
        end
        ST_DIVQ: begin
          if (divs_done) begin
            led_idx_q <= '0;
            state_q   <= ST_READ;
          end
        end
        ST_READ: begin
          state_q <= ST_EVAL;
        end
        ST_EVAL: begin
          em_cnt_q <= em_cnt_d;
          em_pos_q <= 1'b0;
          if (em_cnt_d != 2'd0) begin
            state_q <= ST_EMIT;
          end else if (last_led) begin
            state_q <= ST_FIN;
          end else begin
            led_idx_q <= led_idx_q + 1'b1;
            state_q   <= ST_READ;
          end
        end
        ST_EMIT: begin
          if (!pend_valid_q || out_free) begin
            pend_valid_q <= 1'b1;
            if (2'(em_pos_q) == em_cnt_q - 2'd1) begin
              if (last_led) begin
                state_q <= ST_FIN;
              end else begin
                led_idx_q <= led_idx_q + 1'b1;
                state_q   <= ST_READ;
              end
            end else begin
              em_pos_q <= 1'b1;
            end
          end
        end
        ST_FIN: begin
          if (!pend_valid_q) begin
            state_q <= ST_IDLE;
          end else if (out_free) begin
            pend_valid_q <= 1'b0;
            state_q      <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_beat) events_q <= in_if.events;
    if (state_q == ST_DIVS && divs_done) begin
      steps_in_q  <= quo_in[RegW-1:0];
      steps_off_q <= quo_off[RegW-1:0];
    end
    if (state_q == ST_DIVQ && divs_done) begin
      q_in_q  <= quo_in;
      q_off_q <= quo_off;
    end
    if (state_q == ST_EVAL) begin
      product_q    <= lfsm_pkg::ProdW'(q_sel) * lfsm_pkg::ProdW'(fs2);
      ramp_rise_q  <= rising;
      em_kind_q[0] <= em_k0_d;
      em_kind_q[1] <= em_k1_d;
    end
    if (state_q == ST_EMIT && (!pend_valid_q || out_free)) begin
      pend_led_q  <= 2'(led_idx_q);
      pend_duty_q <= duty_sel;
      if (pend_valid_q) begin
        out_led_q  <= pend_led_q;
        out_duty_q <= pend_duty_q;
        out_last_q <= 1'b0;
      end
    end
    if (state_q == ST_FIN && pend_valid_q && out_free) begin
      out_led_q  <= pend_led_q;
      out_duty_q <= pend_duty_q;
      out_last_q <= 1'b1;
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.led   = out_led_q;
  assign out_if.duty  = out_duty_q;
  assign out_if.last  = out_last_q;

`ifndef SYNTHESIS
  // No result may be left pending once the sequencer is back at rest.
  a_idle_no_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> !pend_valid_q)
    else $error("pending result left behind at end of tick");

  // The emit position always points inside the queued updates.
  a_emit_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT) |-> (2'(em_pos_q) < em_cnt_q))
    else $error("emit position beyond queued updates");

  // With a zero period a tick beat leaves the divider at zero.
  a_period_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_beat && period_q == '0) |=> (tick_div_q == '0))
    else $error("tick divider moved while disabled");

  // Dividers are quiet whenever a tick beat can be taken.
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE) |-> (!busy_in && !busy_off))
    else $error("divider busy while idle");
`endif

endmodule

// File: verif/tb_top.sv
// Testbench for the LED fade controller: drives ticks and register writes and checks
// every duty beat against a scoreboard that tracks the divider and each LED's state.
// Depends on lfsm_pkg, the lfsm_in_if/lfsm_out_if interfaces and led_fade_state_machine.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned LedCount   = 4;
  localparam int unsigned RandTicks  = 200;
  localparam int unsigned SettleCyc  = 300;
  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned ReportMax  = 10;

  // Scoreboard: tracks the divider, LED modes and fade steps, and queues the
  // duty beats that each accepted tick should produce.
  class fade_scoreboard;
    typedef struct {
      logic [1:0]  led;
      logic [15:0] duty;
      logic        last;
    } duty_beat_t;

    logic [15:0] period, fade_in, fade_off, duty_floor, duty_ceil;
    logic [15:0] divider;
    logic [2:0]  mode [LedCount];
    logic [15:0] step_cnt [LedCount];
    duty_beat_t  tick_duties [$];
    duty_beat_t  pending_duties [$];
    int unsigned mismatches, beats_checked, service_ticks;

    function new();
      period        = '0;
      fade_in       = '0;
      fade_off      = '0;
      duty_floor    = '0;
      duty_ceil     = '0;
      divider       = '0;
      mismatches    = 0;
      beats_checked = 0;
      service_ticks = 0;
      for (int i = 0; i < LedCount; i++) begin
        mode[i]     = lfsm_pkg::MODE_OFF;
        step_cnt[i] = '0;
      end
    endfunction

    function void set_reg(logic [2:0] idx, logic [15:0] val);
      case (idx)
        lfsm_pkg::REG_PERIOD:   period     = val;
        lfsm_pkg::REG_FADE_IN:  fade_in    = val;
        lfsm_pkg::REG_FADE_OFF: fade_off   = val;
        lfsm_pkg::REG_PWM_MIN:  duty_floor = val;
        lfsm_pkg::REG_PWM_MAX:  duty_ceil  = val;
        default: ;
      endcase
    endfunction

    // Next mode for one LED; codes above force off behave as no event.
    function logic [2:0] mode_after(logic [2:0] cur, logic [2:0] code);
      logic [2:0] ev;
      logic [2:0] nxt;
      ev  = (code > lfsm_pkg::EV_FORCE_OFF) ? lfsm_pkg::EV_NONE : code;
      nxt = lfsm_pkg::MODE_KEEP;
      case (cur)
        lfsm_pkg::MODE_OFF: begin
          if (ev == lfsm_pkg::EV_ON) nxt = lfsm_pkg::MODE_FADE_IN;
          else if (ev == lfsm_pkg::EV_FORCE_ON) nxt = lfsm_pkg::MODE_ON;
        end
        lfsm_pkg::MODE_ON: begin
          if (ev == lfsm_pkg::EV_OFF) nxt = lfsm_pkg::MODE_FADE_OFF;
          else if (ev == lfsm_pkg::EV_FORCE_OFF) nxt = lfsm_pkg::MODE_OFF;
        end
        default: begin
          if (ev == lfsm_pkg::EV_OFF || ev == lfsm_pkg::EV_FORCE_OFF) nxt = lfsm_pkg::MODE_OFF;
          else if (ev == lfsm_pkg::EV_FORCE_ON) nxt = lfsm_pkg::MODE_ON;
        end
      endcase
      return nxt;
    endfunction

    function void push_duty(int unsigned led, logic [15:0] duty);
      if (tick_duties.size() < 8) tick_duties.push_back('{led[1:0], duty, 1'b0});
    endfunction

    // Exit and entry actions of a mode change.
    function void change_mode(int unsigned i, logic [2:0] to);
      if (mode[i] == lfsm_pkg::MODE_FADE_IN) step_cnt[i] = '0;
      else if (mode[i] == lfsm_pkg::MODE_FADE_OFF) push_duty(i, 16'd0);
      mode[i] = to;
      if (to == lfsm_pkg::MODE_OFF) push_duty(i, 16'd0);
      else if (to == lfsm_pkg::MODE_ON) push_duty(i, duty_ceil);
      else step_cnt[i] = '0;
    endfunction

    // One service step of a fade: advance, finish, or emit the clamped ramp.
    function void fade_update(int unsigned i, bit rising);
      logic [15:0] span, steps;
      logic [63:0] diff, ramp;
      logic [31:0] duty;
      span  = rising ? fade_in : fade_off;
      steps = span / period;
      if (step_cnt[i] != 16'hFFFF) step_cnt[i]++;
      if (step_cnt[i] >= steps) begin
        change_mode(i, rising ? lfsm_pkg::MODE_ON : lfsm_pkg::MODE_OFF);
        return;
      end
      diff = (duty_ceil > duty_floor) ? 64'(duty_ceil - duty_floor) : 64'd0;
      ramp = (((diff << lfsm_pkg::FracBits) / steps) * step_cnt[i]) >> lfsm_pkg::FracBits;
      if (rising) duty = ramp[31:0];
      else if (ramp > duty_ceil) duty = duty_ceil;
      else duty = duty_ceil - ramp[31:0];
      if (duty > duty_ceil) duty = duty_ceil;
      else if (duty < duty_floor) duty = duty_floor;
      push_duty(i, duty[15:0]);
    endfunction

    // Called for every accepted tick beat.
    function void note_tick(logic [11:0] ev_all);
      logic [16:0] cnt;
      logic [2:0]  to;
      tick_duties.delete();
      if (period == 0) begin
        divider = '0;
        return;
      end
      cnt = {1'b0, divider} + 17'd1;
      if (cnt < period) begin
        divider = cnt[15:0];
        return;
      end
      divider = '0;
      service_ticks++;
      for (int i = 0; i < LedCount; i++) begin
        to = mode_after(mode[i], ev_all[3*i +: 3]);
        if (to != lfsm_pkg::MODE_KEEP) change_mode(i, to);
        if (mode[i] == lfsm_pkg::MODE_FADE_IN) fade_update(i, 1'b1);
        else if (mode[i] == lfsm_pkg::MODE_FADE_OFF) fade_update(i, 1'b0);
      end
      if (tick_duties.size() > 0) tick_duties[tick_duties.size() - 1].last = 1'b1;
      foreach (tick_duties[k]) pending_duties.push_back(tick_duties[k]);
    endfunction

    function void note_mismatch(string msg);
      mismatches++;
      if (mismatches <= ReportMax) $display("mismatch: %s", msg);
    endfunction

    // Called for every accepted duty beat.
    function void check_duty(logic [1:0] led, logic [15:0] duty, logic last);
      duty_beat_t want;
      beats_checked++;
      if (pending_duties.size() == 0) begin
        note_mismatch($sformatf("unexpected beat led %0d duty %0d last %0b", led, duty, last));
        return;
      end
      want = pending_duties.pop_front();
      if (want.led !== led || want.duty !== duty || want.last !== last)
        note_mismatch($sformatf("expected led %0d duty %0d last %0b, got led %0d duty %0d last %0b",
                                want.led, want.duty, want.last, led, duty, last));
    endfunction
  endclass

  fade_scoreboard sb;
  logic           clk_i = 1'b0;
  logic           rst_ni;
  logic           cfg_we_i;
  logic [2:0]     cfg_idx_i;
  logic [15:0]    cfg_wdata_i;
  bit             calm;
  int unsigned    cycles = 0;
  int unsigned    ticks_sent = 0;
  int unsigned    settings_used = 0;

  lfsm_in_if  in_if ();
  lfsm_out_if out_if ();

  led_fade_state_machine #(.LED_COUNT(LedCount)) u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_if       (in_if),
    .out_if      (out_if)
  );

  // 10 ns clock.
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("timeout: %0d duty beats still outstanding", sb.pending_duties.size());
      $display("FAIL led_fade_state_machine");
      $finish;
    end
  end

  // Result side: random backpressure except during calm phases.
  always @(negedge clk_i) out_if.ready <= calm || ($urandom_range(99) >= 15);

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_duty(out_if.led, out_if.duty, out_if.last);
  end

  function automatic logic [11:0] pack_events(logic [2:0] e0, e1, e2, e3);
    return {e3, e2, e1, e0};
  endfunction

  // Weighted per-LED event; mostly quiet so that fades can run their course.
  function automatic logic [2:0] pick_event();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 45) return lfsm_pkg::EV_NONE;
    else if (r < 60) return lfsm_pkg::EV_ON;
    else if (r < 73) return lfsm_pkg::EV_OFF;
    else if (r < 83) return lfsm_pkg::EV_FORCE_ON;
    else if (r < 93) return lfsm_pkg::EV_FORCE_OFF;
    // Unassigned codes, which act as no event.
    else return 3'($urandom_range(5, 7));
  endfunction

  function automatic logic [15:0] pick_level();
    int unsigned r;
    r = $urandom_range(5);
    if (r == 0) return 16'd0;
    else if (r == 1) return 16'hFFFF;
    else return 16'($urandom);
  endfunction

  // One tick beat; the model sees it at the edge where it is accepted.
  task automatic send_tick(input logic [11:0] ev);
    while (!calm && $urandom_range(99) < 15) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.events <= ev;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_tick(ev);
    ticks_sent++;
    @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [15:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    sb.set_reg(idx, val);
    @(negedge clk_i);
  endtask

  task automatic load_settings(input logic [15:0] per, fin, fof, lo, hi);
    write_reg(lfsm_pkg::REG_PERIOD, per);
    write_reg(lfsm_pkg::REG_FADE_IN, fin);
    write_reg(lfsm_pkg::REG_FADE_OFF, fof);
    write_reg(lfsm_pkg::REG_PWM_MIN, lo);
    write_reg(lfsm_pkg::REG_PWM_MAX, hi);
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // Drain all expected beats, then allow a service step with no output to finish.
  task automatic settle();
    in_if.valid <= 1'b0;
    while (sb.pending_duties.size() != 0) @(negedge clk_i);
    repeat (SettleCyc) @(negedge clk_i);
  endtask

  // Random settings followed by a run of ticks; a disabled phase uses period zero.
  task automatic random_phase(input int unsigned len, input bit enabled);
    logic [15:0] per, fin, fof, lo, hi;
    per = enabled ? 16'($urandom_range(1, 4)) : 16'd0;
    fin = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom_range(0, per * 12));
    fof = ($urandom_range(9) == 0) ? 16'hFFFF : 16'($urandom_range(0, per * 12));
    lo  = pick_level();
    hi  = pick_level();
    // Keep the floor under the ceiling most of the time.
    if (lo > hi && $urandom_range(3) != 0) {lo, hi} = {hi, lo};
    load_settings(per, fin, fof, lo, hi);
    repeat (len) begin
      if ($urandom_range(4) == 0) send_tick(12'($urandom));
      else send_tick(pack_events(pick_event(), pick_event(), pick_event(), pick_event()));
    end
    settle();
  endtask

  initial begin
    int unsigned n;
    int unsigned len;
    int unsigned phase;
    sb           = new();
    rst_ni       = 1'b0;
    cfg_we_i     = 1'b0;
    cfg_idx_i    = '0;
    cfg_wdata_i  = '0;
    in_if.valid  = 1'b0;
    in_if.events = '0;
    out_if.ready = 1'b0;
    calm         = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Registers at reset: period zero, so ticks are ignored.
    send_tick(pack_events(lfsm_pkg::EV_ON, lfsm_pkg::EV_FORCE_ON, lfsm_pkg::EV_OFF,
                          lfsm_pkg::EV_FORCE_OFF));
    send_tick(12'hFFF);
    settle();

    // Transitions out of every mode, with a service step on each tick.
    load_settings(16'd1, 16'd4, 16'd3, 16'd100, 16'd1000);
    send_tick(pack_events(lfsm_pkg::EV_ON, lfsm_pkg::EV_FORCE_ON, lfsm_pkg::EV_ON, 3'd7));
    send_tick(pack_events(lfsm_pkg::EV_NONE, lfsm_pkg::EV_OFF, lfsm_pkg::EV_OFF,
                          lfsm_pkg::EV_FORCE_ON));
    send_tick(pack_events(lfsm_pkg::EV_FORCE_ON, lfsm_pkg::EV_FORCE_ON, lfsm_pkg::EV_ON,
                          lfsm_pkg::EV_OFF));
    send_tick(pack_events(lfsm_pkg::EV_OFF, lfsm_pkg::EV_OFF, lfsm_pkg::EV_FORCE_OFF,
                          lfsm_pkg::EV_OFF));
    send_tick(pack_events(lfsm_pkg::EV_FORCE_OFF, lfsm_pkg::EV_NONE, 3'd5,
                          lfsm_pkg::EV_FORCE_ON));
    send_tick(pack_events(lfsm_pkg::EV_ON, lfsm_pkg::EV_FORCE_OFF, 3'd6, lfsm_pkg::EV_OFF));
    repeat (4) send_tick(pack_events(lfsm_pkg::EV_NONE, lfsm_pkg::EV_NONE, lfsm_pkg::EV_NONE,
                                     lfsm_pkg::EV_NONE));
    send_tick(pack_events(lfsm_pkg::EV_OFF, lfsm_pkg::EV_FORCE_ON, lfsm_pkg::EV_ON,
                          lfsm_pkg::EV_FORCE_OFF));
    repeat (3) send_tick(12'h000);
    settle();

    // Fade-in shorter than a period, and a floor above the ceiling.
    load_settings(16'd1, 16'd0, 16'd6, 16'd5000, 16'd2000);
    send_tick(pack_events(lfsm_pkg::EV_ON, lfsm_pkg::EV_FORCE_ON, lfsm_pkg::EV_NONE,
                          lfsm_pkg::EV_NONE));
    send_tick(pack_events(lfsm_pkg::EV_NONE, lfsm_pkg::EV_OFF, lfsm_pkg::EV_NONE,
                          lfsm_pkg::EV_NONE));
    repeat (2) send_tick(12'h000);
    settle();

    // Longest period: the divider only counts up.
    load_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
    repeat (3) send_tick(pack_events(lfsm_pkg::EV_ON, lfsm_pkg::EV_ON, lfsm_pkg::EV_FORCE_ON,
                                     lfsm_pkg::EV_ON));
    settle();

    // Period dropped below the divider: the next tick services at once.
    load_settings(16'd2, 16'hFFFF, 16'hFFFF, 16'd0, 16'hFFFF);
    send_tick(pack_events(lfsm_pkg::EV_ON, lfsm_pkg::EV_FORCE_ON, lfsm_pkg::EV_NONE,
                          lfsm_pkg::EV_NONE));
    send_tick(pack_events(lfsm_pkg::EV_NONE, lfsm_pkg::EV_OFF, lfsm_pkg::EV_NONE,
                          lfsm_pkg::EV_NONE));
    send_tick(12'h000);
    settle();

    // Random phases; one runs without idling, one is disabled by period zero.
    n     = 0;
    phase = 0;
    while (n < RandTicks) begin
      calm = (phase == 2);
      len  = $urandom_range(20, 40);
      random_phase(len, phase != 3);
      if (phase != 3) n += len;
      phase++;
    end
    calm = 1'b0;
    settle();

    $display("%0d ticks under %0d register settings, %0d service steps, %0d duty beats checked",
             ticks_sent, settings_used, sb.service_ticks, sb.beats_checked);
    $display("%0d mismatches", sb.mismatches);
    if (sb.mismatches == 0) begin
      $display("PASS led_fade_state_machine");
    end else begin
      $display("FAIL led_fade_state_machine");
    end
    $finish;
  end

endmodule

// File: sim.f
rtl/lfsm_pkg.sv
rtl/lfsm_if.sv
rtl/lfsm_div.sv
rtl/led_fade_state_machine.sv
verif/tb_top.sv
